>>> hw/rtl/nec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NEC pulse decoder package
// Field widths, register indexes, reset values and the window compare shared
// by the pulse decoder, its channel interfaces and its checker.
// ----------------------------------------------------------------------------
package nec_pkg;

  localparam int DUR_W  = 16;
  localparam int CODE_W = 32;
  localparam int WIN_W  = 32;
  localparam int IDX_W  = 8;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_WIN   = 6;

  typedef logic [DUR_W-1:0]     dur_t;
  typedef logic [CODE_W-1:0]    code_t;
  typedef logic [WIN_W-1:0]     win_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HDR_MARK  = 3'd0,
    CFG_HDR_SPACE = 3'd1,
    CFG_RPT_SPACE = 3'd2,
    CFG_BIT_MARK  = 3'd3,
    CFG_ONE_SPACE = 3'd4,
    CFG_ZERO_SPACE = 3'd5
  } cfg_reg_t;

  localparam win_t HDR_MARK_RST   = 32'd20447482;
  localparam win_t HDR_SPACE_RST  = 32'd10223741;
  localparam win_t RPT_SPACE_RST  = 32'd5111870;
  localparam win_t BIT_MARK_RST   = 32'd1441806;
  localparam win_t ONE_SPACE_RST  = 32'd3932205;
  localparam win_t ZERO_SPACE_RST = 32'd1441806;

  localparam int   REPEAT_ENTRIES   = 4;
  localparam int   DATA_MIN_ENTRIES = 68;
  localparam idx_t RPT_LAST_IDX  = IDX_W'(REPEAT_ENTRIES - 1);
  localparam idx_t DATA_LAST_IDX = IDX_W'(DATA_MIN_ENTRIES - 1);
  localparam idx_t MAX_IDX       = {IDX_W{1'b1}};
  localparam idx_t HDR_MARK_IDX  = IDX_W'(1);
  localparam idx_t HDR_SPACE_IDX = IDX_W'(2);
  localparam idx_t FIRST_BIT_IDX = IDX_W'(3);

  // Inclusive window test, low limit in the lower half, high limit in the upper.
  function automatic logic in_window(input dur_t dur, input win_t win);
    in_window = (dur >= win[DUR_W-1:0]) && (dur <= win[WIN_W-1:DUR_W]);
  endfunction

endpackage

>>> hw/rtl/nec_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NEC pulse decoder channel interfaces
// Valid/ready channels for pulse durations, decoded results and register
// writes. A transfer happens on a rising edge with valid and ready high.
// ----------------------------------------------------------------------------
interface nec_in_if import nec_pkg::*; ();
  logic valid;
  logic ready;
  dur_t duration;
  logic last;

  modport source (output valid, output duration, output last, input ready);
  modport sink (input valid, input duration, input last, output ready);
endinterface

interface nec_out_if import nec_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  ok;
  logic  is_repeat;
  code_t code;

  modport source (output valid, output ok, output is_repeat, output code, input ready);
  modport sink (input valid, input ok, input is_repeat, input code, output ready);
endinterface

interface nec_cfg_if import nec_pkg::*; ();
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  win_t     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/nec_ir_pulse_decoder.sv
`timescale 1ns / 1ps
// The result of the last duration is registered in the output register.
// Throughput: one duration per cycle, set by the single input stage feeding
// the window compares and the 32-bit shift register in one pass.
// Only a pending result whose output register is still full stalls the input.
// Synchronous active-low reset clears the frame state, the pipeline valids and
// restores the default tick windows.
// ----------------------------------------------------------------------------
// NEC infrared pulse decoder
// Checks each pulse duration against its configured tick window, shifts the
// data bits into a 32-bit code and reports one result per frame.
// ----------------------------------------------------------------------------
module nec_ir_pulse_decoder import nec_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  nec_in_if.sink    in_bus,
  nec_out_if.source out_bus,
  nec_cfg_if.sink   cfg_bus
);

  win_t win_r [NUM_WIN];

  logic s_valid_r;
  dur_t s_dur_r;
  logic s_last_r;

  idx_t  idx_r, idx_nxt;
  code_t shift_r, shift_nxt;
  logic  err_r, err_nxt;
  logic  dsp_ok_r, dsp_ok_nxt;
  logic  rsp_ok_r, rsp_ok_nxt;

  logic  out_valid_r;
  logic  out_ok_r, ok_nxt;
  logic  out_rep_r, rep_nxt;
  code_t out_code_r, code_nxt;

  logic out_free;
  logic s_adv;
  logic s_fire;

  assign out_free = !out_valid_r || out_bus.ready;
  assign s_adv    = !s_last_r || out_free;
  assign s_fire   = s_valid_r && s_adv;
  assign in_bus.ready  = !s_valid_r || s_adv;
  assign cfg_bus.ready = 1'b1;

  assign out_bus.valid     = out_valid_r;
  assign out_bus.ok        = out_ok_r;
  assign out_bus.is_repeat = out_rep_r;
  assign out_bus.code      = out_code_r;

  always_comb begin
    idx_nxt    = idx_r;
    shift_nxt  = shift_r;
    err_nxt    = err_r;
    dsp_ok_nxt = dsp_ok_r;
    rsp_ok_nxt = rsp_ok_r;
    ok_nxt     = 1'b0;
    rep_nxt    = 1'b0;
    code_nxt   = '0;

    if (idx_r == MAX_IDX) begin
      err_nxt = 1'b1;
    end else if (idx_r == HDR_MARK_IDX) begin
      if (!in_window(s_dur_r, win_r[CFG_HDR_MARK])) begin
        err_nxt = 1'b1;
      end
    end else if (idx_r == HDR_SPACE_IDX) begin
      dsp_ok_nxt = in_window(s_dur_r, win_r[CFG_HDR_SPACE]);
      rsp_ok_nxt = in_window(s_dur_r, win_r[CFG_RPT_SPACE]);
    end else if (idx_r >= FIRST_BIT_IDX) begin
      if (idx_r[0]) begin
        // The final odd entry of a data frame is the stop mark and goes unchecked.
        if (!s_last_r || idx_r == FIRST_BIT_IDX) begin
          if (!in_window(s_dur_r, win_r[CFG_BIT_MARK])) begin
            err_nxt = 1'b1;
          end
        end
      end else begin
        if (in_window(s_dur_r, win_r[CFG_ONE_SPACE])) begin
          shift_nxt = {shift_r[CODE_W-2:0], 1'b1};
        end else if (in_window(s_dur_r, win_r[CFG_ZERO_SPACE])) begin
          shift_nxt = {shift_r[CODE_W-2:0], 1'b0};
        end else begin
          err_nxt = 1'b1;
        end
      end
    end

    if (idx_r != MAX_IDX) begin
      idx_nxt = idx_r + IDX_W'(1);
    end

    if (idx_r == RPT_LAST_IDX) begin
      ok_nxt  = !err_nxt && rsp_ok_nxt;
      rep_nxt = ok_nxt;
    end else if (idx_r >= DATA_LAST_IDX) begin
      ok_nxt   = !err_nxt && dsp_ok_nxt;
      code_nxt = ok_nxt ? shift_nxt : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r[CFG_HDR_MARK]   <= HDR_MARK_RST;
      win_r[CFG_HDR_SPACE]  <= HDR_SPACE_RST;
      win_r[CFG_RPT_SPACE]  <= RPT_SPACE_RST;
      win_r[CFG_BIT_MARK]   <= BIT_MARK_RST;
      win_r[CFG_ONE_SPACE]  <= ONE_SPACE_RST;
      win_r[CFG_ZERO_SPACE] <= ZERO_SPACE_RST;
    end else if (cfg_bus.valid) begin
      case (cfg_bus.index)
        CFG_HDR_MARK:   win_r[CFG_HDR_MARK]   <= cfg_bus.data;
        CFG_HDR_SPACE:  win_r[CFG_HDR_SPACE]  <= cfg_bus.data;
        CFG_RPT_SPACE:  win_r[CFG_RPT_SPACE]  <= cfg_bus.data;
        CFG_BIT_MARK:   win_r[CFG_BIT_MARK]   <= cfg_bus.data;
        CFG_ONE_SPACE:  win_r[CFG_ONE_SPACE]  <= cfg_bus.data;
        CFG_ZERO_SPACE: win_r[CFG_ZERO_SPACE] <= cfg_bus.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      s_valid_r <= in_bus.valid;
    end
    if (in_bus.valid && in_bus.ready) begin
      s_dur_r  <= in_bus.duration;
      s_last_r <= in_bus.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      shift_r  <= '0;
      err_r    <= 1'b0;
      dsp_ok_r <= 1'b0;
      rsp_ok_r <= 1'b0;
    end else if (s_fire) begin
      if (s_last_r) begin
        idx_r    <= '0;
        shift_r  <= '0;
        err_r    <= 1'b0;
        dsp_ok_r <= 1'b0;
        rsp_ok_r <= 1'b0;
      end else begin
        idx_r    <= idx_nxt;
        shift_r  <= shift_nxt;
        err_r    <= err_nxt;
        dsp_ok_r <= dsp_ok_nxt;
        rsp_ok_r <= rsp_ok_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s_fire && s_last_r;
    end
    if (out_free && s_fire && s_last_r) begin
      out_ok_r   <= ok_nxt;
      out_rep_r  <= rep_nxt;
      out_code_r <= code_nxt;
    end
  end

endmodule

>>> hw/rtl/nec_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NEC pulse decoder checker
// Port-level assertions on the result channel, bound to the decoder.
// ----------------------------------------------------------------------------
module nec_chk import nec_pkg::*; (
  input logic  clk,
  input logic  rst_n,
  input logic  out_valid,
  input logic  out_ready,
  input logic  out_ok,
  input logic  out_is_repeat,
  input code_t out_code
);

  // A result waiting for a transfer keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ok) &&
      $stable(out_is_repeat) && $stable(out_code))
    else $error("result changed while stalled");

  // No result is pending straight after reset.
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result pending after reset");

  // A failed frame carries no code.
  a_fail_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_code == '0 && !out_is_repeat)
    else $error("failed frame carries a code or repeat flag");

  // A repeat frame is a good frame without a code.
  a_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_repeat |-> out_ok && out_code == '0)
    else $error("repeat result inconsistent");

endmodule

bind nec_ir_pulse_decoder nec_chk u_nec_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_bus.valid),
  .out_ready     (out_bus.ready),
  .out_ok        (out_bus.ok),
  .out_is_repeat (out_bus.is_repeat),
  .out_code      (out_bus.code)
);

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NEC infrared pulse decoder testbench
// Drives random pulse durations as whole frames and checks every result.
// The frames are well-formed data and repeat frames, short, odd-length,
// overlong and noisy frames. A decoder written inside the bench predicts
// each result, and a checker compares it field by field with the block's
// output. The tick windows are reprogrammed between phases, including
// empty, full and degenerate settings. The sender idles in bursts and the
// receiver stalls on a pattern of its own, with one long hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import nec_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_ITEMS   = 450;
  localparam int PHASE_ITEMS    = 120;
  localparam int SETTLE_CYCLES  = 8;

  typedef struct packed {
    logic  ok;
    logic  is_repeat;
    code_t code;
  } frame_result_t;

  logic clk;
  logic rst_n;

  nec_in_if  in_bus ();
  nec_out_if out_bus ();
  nec_cfg_if cfg_bus ();

  nec_ir_pulse_decoder dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  win_t reset_windows [NUM_WIN] = '{HDR_MARK_RST, HDR_SPACE_RST, RPT_SPACE_RST,
                                    BIT_MARK_RST, ONE_SPACE_RST, ZERO_SPACE_RST};

  // Decoder state kept by the bench.
  win_t  tick_windows [NUM_WIN];
  idx_t  entry_pos;
  code_t bit_shift;
  logic  timing_err;
  logic  data_hdr_ok;
  logic  rpt_hdr_ok;

  frame_result_t expected_results [$];

  int errors;
  int items_sent;
  int idle_cycles;
  int stall_left;
  int burst_left;
  bit gaps_on;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic logic fits(input dur_t ticks, input win_t w);
    return (ticks >= w[15:0]) && (ticks <= w[31:16]);
  endfunction

  function automatic dur_t pick_in(input win_t w);
    if (w[15:0] <= w[31:16]) begin
      return dur_t'($urandom_range(w[31:16], w[15:0]));
    end
    return dur_t'($urandom);
  endfunction

  function automatic win_t random_window(input int k);
    int lo;
    int hi;
    case ($urandom_range(0, 9))
      0: return reset_windows[k];
      1: return {16'hFFFF, 16'h0000};
      2: begin
        lo = $urandom_range(1, 65535);
        hi = $urandom_range(0, lo - 1);
        return {hi[15:0], lo[15:0]};
      end
      3: return win_t'($urandom);
      default: begin
        lo = $urandom_range(0, 65000);
        hi = lo + $urandom_range(0, 500);
        return {hi[15:0], lo[15:0]};
      end
    endcase
  endfunction

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) begin
      $display("%0t: %s", $time, msg);
    end
  endtask

  task automatic clear_frame_state();
    entry_pos   = '0;
    bit_shift   = '0;
    timing_err  = 1'b0;
    data_hdr_ok = 1'b0;
    rpt_hdr_ok  = 1'b0;
  endtask

  task automatic decode_entry(input dur_t ticks, input logic is_last);
    idx_t          pos;
    frame_result_t res;
    pos = entry_pos;
    if (pos == MAX_IDX) begin
      timing_err = 1'b1;
    end else if (pos == HDR_MARK_IDX) begin
      if (!fits(ticks, tick_windows[CFG_HDR_MARK])) timing_err = 1'b1;
    end else if (pos == HDR_SPACE_IDX) begin
      data_hdr_ok = fits(ticks, tick_windows[CFG_HDR_SPACE]);
      rpt_hdr_ok  = fits(ticks, tick_windows[CFG_RPT_SPACE]);
    end else if (pos >= FIRST_BIT_IDX) begin
      if (pos[0]) begin
        // The stop mark of a data frame is not checked; the end mark of a repeat frame is.
        if (!is_last || pos == FIRST_BIT_IDX) begin
          if (!fits(ticks, tick_windows[CFG_BIT_MARK])) timing_err = 1'b1;
        end
      end else if (fits(ticks, tick_windows[CFG_ONE_SPACE])) begin
        bit_shift = {bit_shift[CODE_W-2:0], 1'b1};
      end else if (fits(ticks, tick_windows[CFG_ZERO_SPACE])) begin
        bit_shift = {bit_shift[CODE_W-2:0], 1'b0};
      end else begin
        timing_err = 1'b1;
      end
    end
    if (pos != MAX_IDX) entry_pos = pos + 1'b1;
    if (is_last) begin
      res = '0;
      if (pos == RPT_LAST_IDX) begin
        res.ok        = !timing_err && rpt_hdr_ok;
        res.is_repeat = res.ok;
      end else if (pos >= DATA_LAST_IDX) begin
        res.ok   = !timing_err && data_hdr_ok;
        res.code = res.ok ? bit_shift : '0;
      end
      expected_results.push_back(res);
      clear_frame_state();
    end
  endtask

  task automatic send_duration(input dur_t ticks, input logic is_last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0 || !gaps_on) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_bus.valid    <= 1'b1;
    in_bus.duration <= ticks;
    in_bus.last     <= is_last;
    do @(posedge clk); while (!in_bus.ready);
    items_sent++;
    decode_entry(ticks, is_last);
  endtask

  task automatic send_frame(input int len, input int bad_pct, input code_t bits,
                            input int bad_idx);
    dur_t ticks;
    int   bit_pos;
    bit_pos = CODE_W - 1;
    for (int i = 0; i < len; i++) begin
      if (i == 0) begin
        ticks = dur_t'($urandom);
      end else if (i == 1) begin
        ticks = pick_in(tick_windows[CFG_HDR_MARK]);
      end else if (i == 2) begin
        ticks = pick_in(tick_windows[(len == REPEAT_ENTRIES) ? CFG_RPT_SPACE : CFG_HDR_SPACE]);
      end else if (i % 2 == 1) begin
        ticks = pick_in(tick_windows[CFG_BIT_MARK]);
      end else begin
        ticks = pick_in(tick_windows[bits[bit_pos] ? CFG_ONE_SPACE : CFG_ZERO_SPACE]);
        bit_pos = (bit_pos == 0) ? CODE_W - 1 : bit_pos - 1;
      end
      if ($urandom_range(0, 99) < bad_pct) ticks = dur_t'($urandom);
      if (i == bad_idx) ticks = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      send_duration(ticks, i == len - 1);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input cfg_reg_t sel, input win_t value);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= sel;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    tick_windows[sel] = value;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic set_all_windows(input win_t value);
    drain_results();
    for (int k = 0; k < NUM_WIN; k++) write_window(cfg_reg_t'(k), value);
  endtask

  task automatic test_default_windows();
    gaps_on = 1'b1;
    send_frame(68, 0, 32'hA5A5_0FF0, -1);
    send_frame(4, 0, '0, -1);
    send_frame(4, 0, '0, 2);
    send_frame(4, 0, '0, 3);
    send_frame(69, 0, 32'h1234_5678, -1);
    send_frame(72, 0, 32'hDEAD_BEEF, -1);
    send_frame(12, 0, 32'hFFFF_0000, -1);
    send_frame(68, 0, 32'h0F0F_F0F0, 36);
    send_frame(68, 0, 32'h8000_0001, 1);
    send_frame(68, 0, 32'hFFFF_FFFF, 66);
    send_frame(1, 0, '0, 0);
    send_frame(260, 0, 32'h5555_AAAA, -1);
  endtask

  task automatic test_window_extremes();
    win_t settings [4] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'hFFFF_0000};
    foreach (settings[s]) begin
      set_all_windows(settings[s]);
      send_frame(68, 0, $urandom, -1);
      send_frame(4, 0, '0, -1);
      send_frame(70, 0, $urandom, -1);
    end
    drain_results();
    for (int k = 0; k < NUM_WIN; k++) write_window(cfg_reg_t'(k), reset_windows[k]);
  endtask

  task automatic test_output_hold_off();
    drain_results();
    gaps_on    = 1'b0;
    stall_left = 400;
    repeat (12) send_frame(4, 0, '0, -1);
    send_frame(68, 0, $urandom, -1);
    send_frame(68, 0, $urandom, -1);
    drain_results();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_frames();
    int start_items;
    int phase_start;
    int kind;
    start_items  = items_sent;
    phase_start  = items_sent;
    while (items_sent - start_items < RANDOM_ITEMS) begin
      if (items_sent - phase_start >= PHASE_ITEMS) begin
        drain_results();
        for (int k = 0; k < NUM_WIN; k++) write_window(cfg_reg_t'(k), random_window(k));
        gaps_on     = ($urandom_range(0, 3) != 0);
        phase_start = items_sent;
      end
      kind = $urandom_range(0, 99);
      if (kind < 40)      send_frame(68, 0, $urandom, -1);
      else if (kind < 60) send_frame(4, 0, '0, -1);
      else if (kind < 70) send_frame(68 + $urandom_range(0, 12), 2, $urandom, -1);
      else if (kind < 78) send_frame(68, 0, $urandom, $urandom_range(0, 67));
      else if (kind < 88) send_frame($urandom_range(1, 67), 5, $urandom, -1);
      else if (kind < 96) send_frame($urandom_range(1, 80), 100, '0, -1);
      else                send_frame($urandom_range(250, 262), 0, $urandom, -1);
    end
  endtask

  initial begin : receiver
    logic [15:0] pattern;
    int          pattern_age;
    pattern       = '1;
    pattern_age   = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else begin
        if (pattern_age == 0) begin
          pattern_age = $urandom_range(50, 300);
          case ($urandom_range(0, 3))
            0: pattern = '1;
            1: pattern = 16'($urandom);
            2: pattern = 16'($urandom | $urandom);
            default: pattern = 16'($urandom & $urandom);
          endcase
          if (pattern == '0) pattern = 16'h0001;
        end
        pattern_age--;
        out_bus.ready <= pattern[0];
        pattern = {pattern[0], pattern[15:1]};
      end
    end
  end

  always @(posedge clk) begin : result_check
    frame_result_t exp_r;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_results.size() == 0) begin
        flag_error($sformatf("unexpected result ok=%0b rpt=%0b code=%h",
                             out_bus.ok, out_bus.is_repeat, out_bus.code));
      end else begin
        exp_r = expected_results.pop_front();
        if (out_bus.ok !== exp_r.ok || out_bus.is_repeat !== exp_r.is_repeat ||
            out_bus.code !== exp_r.code) begin
          flag_error($sformatf("mismatch: expected ok=%0b rpt=%0b code=%h, got ok=%0b rpt=%0b code=%h",
                               exp_r.ok, exp_r.is_repeat, exp_r.code,
                               out_bus.ok, out_bus.is_repeat, out_bus.code));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_bus.valid    = 1'b0;
    in_bus.duration = '0;
    in_bus.last     = 1'b0;
    cfg_bus.valid   = 1'b0;
    cfg_bus.index   = CFG_HDR_MARK;
    cfg_bus.data    = '0;
    errors          = 0;
    items_sent      = 0;
    idle_cycles     = 0;
    stall_left      = 0;
    burst_left      = 0;
    gaps_on         = 1'b1;
    for (int k = 0; k < NUM_WIN; k++) tick_windows[k] = reset_windows[k];
    clear_frame_state();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_default_windows();
    test_window_extremes();
    test_output_hold_off();
    test_random_frames();

    drain_results();
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
